[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the checker files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// overlapping implication, held off during reset
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also covers reset itself
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/trm_pkg.sv]
// ----------------------------------------------------------------------------
// trm_pkg
// opcodes and shared types of the tiny register machine execute block
// ----------------------------------------------------------------------------
package trm_pkg;

  // opcodes
  localparam logic [4:0] OP_TEXT  = 5'd0;
  localparam logic [4:0] OP_INC   = 5'd1;
  localparam logic [4:0] OP_DEC   = 5'd2;
  localparam logic [4:0] OP_ADD   = 5'd3;
  localparam logic [4:0] OP_SUB   = 5'd4;
  localparam logic [4:0] OP_SET   = 5'd5;
  localparam logic [4:0] OP_WRITE = 5'd6;
  localparam logic [4:0] OP_READ  = 5'd7;
  localparam logic [4:0] OP_COPY  = 5'd8;
  localparam logic [4:0] OP_CMP   = 5'd9;
  localparam logic [4:0] OP_JEQ   = 5'd10;
  localparam logic [4:0] OP_JNE   = 5'd11;
  localparam logic [4:0] OP_JLB   = 5'd12;
  localparam logic [4:0] OP_JRB   = 5'd13;
  localparam logic [4:0] OP_JZ    = 5'd14;
  localparam logic [4:0] OP_JNZ   = 5'd15;
  localparam logic [4:0] OP_JOVF  = 5'd16;

  localparam int ITEM_BITS   = 32;
  localparam int RESULT_BITS = 32;

  // flags, equal in the lowest bit
  typedef struct packed {
    logic ovf;
    logic zer;
    logic rib;
    logic lib;
    logic equ;
  } trm_flags_t;

  // input item, laid out exactly as the input tdata
  typedef struct packed {
    logic              restart;
    logic [7:0]        read_value;
    logic signed [9:0] amount;
    logic [3:0]        src_reg;
    logic [3:0]        dest_reg;
    logic [4:0]        mode;
  } trm_item_t;

  // machine state seen by the execute unit
  typedef struct packed {
    logic [8:0] pc;
    logic       err;
    trm_flags_t flags;
  } trm_state_t;

  // register file write request
  typedef struct packed {
    logic       en;
    logic [7:0] data;
  } trm_wr_t;

  // result of one item
  typedef struct packed {
    trm_flags_t flags;
    logic [7:0] out_value;
    logic       out_valid;
    logic       jump_error;
    logic       halted;
    logic [8:0] next_pc;
  } trm_result_t;

endpackage

[sv/trm_ram.sv]
// ----------------------------------------------------------------------------
// trm_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module trm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                    wdata,
  input  logic                                re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                    rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, old data on a same-address write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/trm_exec.sv]
// ----------------------------------------------------------------------------
// trm_exec
// instruction execute unit: alu, flag update and jump resolution
// ----------------------------------------------------------------------------
module trm_exec (
  input  trm_pkg::trm_item_t   item,
  input  trm_pkg::trm_state_t  cur,
  input  logic [8:0]           prog_len,
  input  logic [7:0]           a,
  input  logic [7:0]           b,
  output trm_pkg::trm_wr_t     wr,
  output trm_pkg::trm_result_t res
);
  import trm_pkg::*;

  logic [8:0]         pc0;
  logic               err0;
  logic               run;
  logic [7:0]         step8;
  logic [8:0]         sum_ab;
  logic [8:0]         sum_as;
  logic               is_jump;
  logic               taken;
  logic signed [10:0] target;
  logic               bad;
  logic [8:0]         pc_next;
  logic               err_next;
  trm_flags_t         flags_next;
  trm_flags_t         zflag;
  logic               emit_valid;
  logic [7:0]         emit_value;

  // restart clears counter and error first
  assign pc0   = item.restart ? '0 : cur.pc;
  assign err0  = item.restart ? 1'b0 : cur.err;
  assign run   = !err0 && (pc0 < prog_len);
  assign step8 = item.amount[7:0];

  assign sum_as = {1'b0, a} + {1'b0, step8};
  assign sum_ab = {1'b0, a} + {1'b0, b};

  // relative jump target, sign-extended offset
  assign target = $signed({2'b00, pc0}) + 11'(item.amount);
  assign bad    = (target < 0) || (target > $signed({2'b00, prog_len}));

  // opcode decode
  always_comb begin
    wr         = '0;
    flags_next = cur.flags;
    zflag      = '0;
    is_jump    = 1'b0;
    taken      = 1'b0;
    emit_valid = 1'b0;
    emit_value = '0;
    case (item.mode)
      OP_INC: begin
        wr.en = 1'b1;
        wr.data = sum_as[7:0];
        flags_next = '0;
        flags_next.ovf = sum_as[8];
        flags_next.zer = (sum_as[7:0] == 8'd0);
      end
      OP_DEC: begin
        wr.en = 1'b1;
        wr.data = a - step8;
        flags_next = '0;
        flags_next.ovf = (step8 > a);
        flags_next.zer = (a == step8);
      end
      OP_ADD: begin
        wr.en = 1'b1;
        wr.data = sum_ab[7:0];
        flags_next = '0;
        flags_next.ovf = sum_ab[8];
      end
      OP_SUB: begin
        wr.en = 1'b1;
        wr.data = a - b;
        flags_next = '0;
        flags_next.ovf = (b > a);
      end
      OP_SET: begin
        wr.en = 1'b1;
        wr.data = step8;
        zflag.zer = (step8 == 8'd0);
        flags_next = zflag;
      end
      OP_WRITE: begin
        emit_valid = 1'b1;
        emit_value = a;
      end
      OP_READ: begin
        wr.en = 1'b1;
        wr.data = item.read_value;
        zflag.zer = (item.read_value == 8'd0);
        flags_next = zflag;
      end
      OP_COPY: begin
        wr.en = 1'b1;
        wr.data = b;
        zflag.zer = (b == 8'd0);
        flags_next = zflag;
      end
      OP_CMP: begin
        flags_next = '0;
        flags_next.equ = (a == b);
        flags_next.lib = (a > b);
        flags_next.rib = (a < b);
        flags_next.zer = (a == 8'd0);
      end
      OP_JEQ: begin
        is_jump = 1'b1;
        taken = cur.flags.equ;
      end
      OP_JNE: begin
        is_jump = 1'b1;
        taken = !cur.flags.equ;
      end
      OP_JLB: begin
        is_jump = 1'b1;
        taken = cur.flags.lib;
      end
      OP_JRB: begin
        is_jump = 1'b1;
        taken = cur.flags.rib;
      end
      OP_JZ: begin
        is_jump = 1'b1;
        taken = cur.flags.zer;
      end
      OP_JNZ: begin
        is_jump = 1'b1;
        taken = !cur.flags.zer;
      end
      OP_JOVF: begin
        is_jump = 1'b1;
        taken = cur.flags.ovf;
      end
      default: begin
      end
    endcase
    // nothing executes while halted or in error
    if (!run) begin
      wr         = '0;
      flags_next = cur.flags;
      emit_valid = 1'b0;
      emit_value = '0;
    end
  end

  // counter and sticky error
  always_comb begin
    pc_next  = pc0;
    err_next = err0;
    if (run) begin
      if (is_jump && taken) begin
        if (bad) begin
          err_next = 1'b1;
        end else begin
          pc_next = target[8:0];
        end
      end else begin
        pc_next = pc0 + 9'd1;
      end
    end
  end

  assign res.next_pc    = pc_next;
  assign res.halted     = (pc_next >= prog_len);
  assign res.jump_error = err_next;
  assign res.out_valid  = emit_valid;
  assign res.out_value  = emit_value;
  assign res.flags      = flags_next;

endmodule

[sv/tiny_register_machine_execute.sv]
// ----------------------------------------------------------------------------
// tiny_register_machine_execute
// one instruction of a small 8-bit register machine per item
// ----------------------------------------------------------------------------
// on acceptance the item and its register file reads are registered; the execute
// result then enters the output register once that register is free
// throughput: one item per cycle while the output is not stalled, set by the single execute stage
// reset: synchronous; counter, error, flags and length clear, and the
// register file reads zero at once through per-entry valid bits (no sweep)
module tiny_register_machine_execute #(
  parameter int NUM_REGS   = 16,
  parameter int PROG_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  // mode[4:0], dest_reg[8:5], src_reg[12:9], amount[22:13],
  // read_value[30:23], restart[31]
  input  logic [31:0] s_tdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  // next_pc[8:0], halted[9], jump_error[10], out_valid[11], out_value[19:12],
  // flag_equal[20], flag_left_bigger[21], flag_right_bigger[22],
  // flag_zero[23], flag_overflow[24], zero fill[31:25]
  output logic [31:0] m_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // program_length
  input  logic [8:0]  cfg_data,
  input  logic        cfg_valid,
  output logic        cfg_ready
);
  import trm_pkg::*;

  localparam int RF_DEPTH = (NUM_REGS > 16) ? 16 : NUM_REGS;
  localparam int AW       = (RF_DEPTH > 1) ? $clog2(RF_DEPTH) : 1;

  trm_item_t     in_item;
  trm_item_t     s1_item;
  logic          s1_valid;
  logic          out_free;
  logic          go;
  logic          accept;

  logic [7:0]    qa;
  logic [7:0]    qb;
  logic [RF_DEPTH-1:0] rf_valid;
  logic          wb_en;
  logic [AW-1:0] wb_addr;
  logic [7:0]    wb_data;

  logic          d_ok;
  logic          s_ok;
  logic [AW-1:0] d_addr;
  logic [AW-1:0] s_addr;
  logic [7:0]    a_val;
  logic [7:0]    b_val;
  logic          rf_we;

  trm_state_t    state;
  logic [8:0]    prog_len;
  trm_wr_t       wr;
  trm_result_t   res;

  assign in_item = trm_item_t'(s_tdata);

  // pipeline handshake
  assign out_free = !m_tvalid || m_tready;
  assign go       = s1_valid && out_free;
  assign s_tready = !s1_valid || go;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= in_item;
    end
  end

  // register file, one copy per read port
  assign d_ok   = 32'(s1_item.dest_reg) < NUM_REGS;
  assign s_ok   = 32'(s1_item.src_reg) < NUM_REGS;
  assign d_addr = s1_item.dest_reg[AW-1:0];
  assign s_addr = s1_item.src_reg[AW-1:0];
  assign rf_we  = go && wr.en && d_ok;

  trm_ram #(.WIDTH(8), .DEPTH(RF_DEPTH)) u_rf_a (
    .clk   (clk),
    .we    (rf_we),
    .waddr (d_addr),
    .wdata (wr.data),
    .re    (accept),
    .raddr (in_item.dest_reg[AW-1:0]),
    .rdata (qa)
  );

  trm_ram #(.WIDTH(8), .DEPTH(RF_DEPTH)) u_rf_b (
    .clk   (clk),
    .we    (rf_we),
    .waddr (d_addr),
    .wdata (wr.data),
    .re    (accept),
    .raddr (in_item.src_reg[AW-1:0]),
    .rdata (qb)
  );

  // valid bits: unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      rf_valid <= '0;
    end else if (rf_we) begin
      rf_valid[d_addr] <= 1'b1;
    end
  end

  // last write, forwarded over the read that raced it
  always_ff @(posedge clk) begin
    if (rst) begin
      wb_en <= 1'b0;
    end else if (rf_we) begin
      wb_en <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rf_we) begin
      wb_addr <= d_addr;
      wb_data <= wr.data;
    end
  end

  // operand select
  always_comb begin
    a_val = '0;
    b_val = '0;
    if (d_ok) begin
      if (wb_en && (wb_addr == d_addr)) begin
        a_val = wb_data;
      end else if (rf_valid[d_addr]) begin
        a_val = qa;
      end
    end
    if (s_ok) begin
      if (wb_en && (wb_addr == s_addr)) begin
        b_val = wb_data;
      end else if (rf_valid[s_addr]) begin
        b_val = qb;
      end
    end
  end

  trm_exec u_exec (
    .item     (s1_item),
    .cur      (state),
    .prog_len (prog_len),
    .a        (a_val),
    .b        (b_val),
    .wr       (wr),
    .res      (res)
  );

  // machine state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (go) begin
      state.pc    <= res.next_pc;
      state.err   <= res.jump_error;
      state.flags <= res.flags;
    end
  end

  // program length register, saturated to the program depth
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      prog_len <= '0;
    end else if (cfg_valid) begin
      if (32'(cfg_data) > PROG_DEPTH) begin
        prog_len <= 9'(PROG_DEPTH);
      end else begin
        prog_len <= cfg_data;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (go) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      m_tdata <= {7'd0, res};
    end
  end

endmodule

[sv/trm_checker.sv]
// ----------------------------------------------------------------------------
// trm_checker
// port-level checks of the register machine execute block
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module trm_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [31:0] m_tdata,
  input logic        m_tvalid,
  input logic        m_tready
);

  // a stalled result holds
  `ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

  // no result right after reset
  `ASSERT_NEXT_ALWAYS(a_rst_empty, clk, rst, !m_tvalid, "result valid after reset")

  // compare flags are mutually exclusive
  `ASSERT_SAME(a_cmp_onehot, clk, rst, m_tvalid, $onehot0(m_tdata[22:20]), "compare flags not exclusive")

  // emitted value is zero unless a write produced it
  `ASSERT_SAME(a_out_zero, clk, rst, m_tvalid && !m_tdata[11], m_tdata[19:12] == 8'd0, "out_value set without out_valid")

  // an accepted item reaches the output once the output register is free
  `ASSERT_NEXT(a_flow, clk, rst, s_tvalid && s_tready ##1 (!m_tvalid || m_tready), m_tvalid, "accepted item produced no result")

endmodule

bind tiny_register_machine_execute trm_checker u_trm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tdata  (m_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready)
);
